/* design/smallest_unused_value_defines.svh */
// ----------------------------------------------------------------------------
// Smallest unused value - assertion macros
// Shared concurrent assertion wrappers, clocked on aclk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef SMALLEST_UNUSED_VALUE_DEFINES_SVH
`define SMALLEST_UNUSED_VALUE_DEFINES_SVH

// plain property checked every edge
`define SUV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// antecedent now, consequent on the following edge
`define SUV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/suv_pkg.sv */
// ----------------------------------------------------------------------------
// Smallest unused value - package
// Fixed field widths and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package suv_pkg;

    localparam int COLOR_W     = 32;
    localparam int LB_W        = 16;
    localparam int FREE_W      = 17;
    localparam int SUM_W       = 18;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    typedef logic [LB_W-1:0]        lb_t;
    typedef logic [IN_TDATA_W-1:0]  in_tdata_t;
    typedef logic [OUT_TDATA_W-1:0] out_tdata_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } suv_state_t;

endpackage

`default_nettype wire

/* design/smallest_unused_value.sv */
// A beat with a colour in the window is read from the bitmap in ST_IDLE and
// written back in ST_MARK, with s_tready low; any other beat is taken in ST_IDLE.
// A last beat starts a scan of MAP_SIZE/32 rows (2 rows when MAP_SIZE < 64),
// then ST_DRAIN and ST_DONE, where the result beat is loaded; the scan also clears.
// Reset: synchronous, active low; afterwards a clearing pass of one row per
// cycle over every scan row runs with s_tready low.
// ----------------------------------------------------------------------------
// Smallest unused value
// Marks neighbour colours in a used-value bitmap and returns the first free one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "smallest_unused_value_defines.svh"

module smallest_unused_value #(
    parameter int MAP_SIZE = 1024
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    // config
    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  wire  suv_pkg::lb_t       cfg_data,     // lower_bound
    // input stream
    input  wire                      s_tvalid,
    output logic                     s_tready,
    input  wire  suv_pkg::in_tdata_t s_tdata,      // [31:0] color_value
    input  wire  [0:0]               s_tuser,      // [0] has_value
    input  wire                      s_tlast,      // last_item
    // result stream
    output logic                     m_tvalid,
    input  wire                      m_tready,
    output suv_pkg::out_tdata_t      m_tdata,      // [16:0] free_value, rest zero
    output logic [0:0]               m_tuser       // [0] overflow
);
    import suv_pkg::*;

    localparam int WORD_W = (MAP_SIZE >= 64) ? 32 : MAP_SIZE / 2;
    localparam int ROWS   = MAP_SIZE / WORD_W;
    localparam int ROW_AW = $clog2(ROWS);
    localparam int BIT_AW = $clog2(WORD_W);
    localparam int MAP_AW = $clog2(MAP_SIZE);
    localparam int CNT_W  = MAP_AW + 1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ROW_AW-1:0] row_t;
    typedef logic [BIT_AW-1:0] bit_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // bitmap RAM
    word_t             mem [ROWS];
    word_t             mem_rdata_reg;
    logic              mem_we;
    logic              mem_re;
    row_t              mem_waddr;
    row_t              mem_raddr;
    word_t             mem_wdata;

    suv_state_t        state_reg, state_next;
    lb_t               lb_reg;
    cnt_t              count_reg, count_next;
    logic              ovf_reg, ovf_next;
    row_t              mark_row_reg, mark_row_next;
    bit_t              mark_bit_reg, mark_bit_next;
    logic              last_reg, last_next;
    row_t              scan_row_reg, scan_row_next;
    row_t              rd_row_reg;
    logic              chk_valid_reg;
    logic              found_reg;
    cnt_t              first_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [FREE_W-1:0] free_reg;
    logic              ovf_out_reg;

    logic              in_accept;
    logic              has_value;
    logic [COLOR_W-1:0] offset;
    logic              in_window;
    logic              out_load;
    bit_t              zero_idx;
    logic              word_has_zero;
    logic [SUM_W-1:0]  free_sum;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign has_value = s_tuser[0];

    assign offset    = s_tdata - COLOR_W'(lb_reg);
    assign in_window = has_value && !s_tdata[COLOR_W-1] && (s_tdata >= COLOR_W'(lb_reg))
                       && (offset[COLOR_W-1:MAP_AW] == '0);

    // first clear bit of the word just read
    always_comb begin
        zero_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!mem_rdata_reg[i]) begin
                zero_idx = BIT_AW'(i);
            end
        end
    end
    assign word_has_zero = (mem_rdata_reg != '1);

    assign free_sum = SUM_W'(lb_reg) + SUM_W'(first_reg);
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        mark_row_next = mark_row_reg;
        mark_bit_next = mark_bit_reg;
        last_next     = last_reg;
        scan_row_next = scan_row_reg;
        m_tvalid_next = m_tvalid_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = scan_row_reg;
        mem_raddr     = scan_row_reg;
        mem_wdata     = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                scan_row_next = scan_row_reg + 1'b1;
                if (scan_row_reg == row_t'(ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    if (has_value) begin
                        if (count_reg == cnt_t'(MAP_SIZE)) begin
                            ovf_next = 1'b1;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    mark_row_next = offset[MAP_AW-1:BIT_AW];
                    mark_bit_next = offset[BIT_AW-1:0];
                    last_next     = s_tlast;
                    if (in_window) begin
                        mem_re     = 1'b1;
                        mem_raddr  = offset[MAP_AW-1:BIT_AW];
                        state_next = ST_MARK;
                    end else if (s_tlast) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_MARK: begin
                mem_we     = 1'b1;
                mem_waddr  = mark_row_reg;
                mem_wdata  = mem_rdata_reg | (word_t'(1) << mark_bit_reg);
                state_next = last_reg ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                // read each row and zero it behind the read
                mem_re        = 1'b1;
                mem_we        = 1'b1;
                scan_row_next = scan_row_reg + 1'b1;
                if (scan_row_reg == row_t'(ROWS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    count_next    = '0;
                    ovf_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            lb_reg        <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            scan_row_reg  <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            scan_row_reg  <= scan_row_next;
            chk_valid_reg <= (state_reg == ST_SCAN);
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                lb_reg <= cfg_data;
            end
            if (state_reg == ST_IDLE) begin
                found_reg <= 1'b0;
            end else if (chk_valid_reg && !found_reg && word_has_zero) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mark_row_reg <= mark_row_next;
        mark_bit_reg <= mark_bit_next;
        last_reg     <= last_next;
        rd_row_reg   <= scan_row_reg;
        if (state_reg == ST_IDLE) begin
            first_reg <= cnt_t'(MAP_SIZE);
        end else if (chk_valid_reg && !found_reg && word_has_zero) begin
            first_reg <= cnt_t'({rd_row_reg, zero_idx});
        end
        if (out_load) begin
            free_reg    <= free_sum[FREE_W-1:0];
            ovf_out_reg <= ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(free_reg);
    assign m_tuser  = ovf_out_reg;

    `SUV_ASSERT(a_no_accept_busy, (state_reg != ST_IDLE |-> !s_tready), "input taken while busy")
    `SUV_ASSERT(a_count_bound, (count_reg <= cnt_t'(MAP_SIZE)), "item count above map size")
    `SUV_ASSERT_NEXT(a_list_reset, out_load, (count_reg == '0 && !ovf_reg), "stale list state")

endmodule

`default_nettype wire
